// ===== rtl/hcb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared types, sizes and codes of the halo coupling COO builder.
// ----------------------------------------------------------------------------
package hcb_pkg;

  localparam int MAX_CELLS = 1024;
  localparam int MAX_NEIGH = 8;
  localparam int MAX_DOF   = 2;
  localparam int MAX_EQ    = 4096;

  localparam int CELL_W  = 10;   // cell_req field
  localparam int SLOT_W  = 3;
  localparam int VAL_W   = 14;
  localparam int CMD_W   = 3;
  localparam int ROW_W   = 13;
  localparam int RES_W   = 16;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 13;
  localparam int NEQ_W   = 13;
  localparam int DOFS_W  = 2;
  localparam int NCELL_W = 11;

  localparam int DOF_W   = (MAX_DOF > 1) ? $clog2(MAX_DOF) : 1;
  localparam int NB_SW   = (MAX_NEIGH > 1) ? $clog2(MAX_NEIGH) : 1;
  localparam int NCNT_W  = $clog2(MAX_NEIGH + 1);
  localparam int ND_W    = $clog2(MAX_DOF + 1);
  localparam int CIDX_W  = $clog2(MAX_CELLS);
  localparam int EQ_AW   = $clog2(MAX_CELLS * MAX_DOF);
  localparam int NB_AW   = $clog2(MAX_CELLS * MAX_NEIGH);
  localparam int EQ_VW   = $clog2(MAX_EQ + 1);
  localparam int NB_VW   = $clog2(MAX_CELLS + 1);
  localparam int RP_AW   = $clog2(MAX_EQ + 2);
  localparam int RP_DEPTH = MAX_EQ + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR    = 3'd0,
    CMD_LOAD_EQ  = 3'd1,
    CMD_LOAD_NB  = 3'd2,
    CMD_LOAD_CNT = 3'd3,
    CMD_PROCESS  = 3'd4
  } cmd_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_NUM_EQ    = 2'd0,
    CFG_DOFS      = 2'd1,
    CFG_NUM_CELLS = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CNT_RD, ST_ROW_RD, ST_ROW_CHK, ST_EQ_RD, ST_EQ_CHK,
    ST_NB_SEL, ST_NB_CHK, ST_RP_RD, ST_RP_EMIT, ST_FLUSH
  } state_t;

  typedef struct packed {
    logic accept;
    logic start;
    logic clr_start;
    logic clr_step;
    logic cnt_rd;
    logic row_rd;
    logic row_take;
    logic jd_inc;
    logic eq_rd;
    logic push_pair;
    logic d_inc;
    logic eq_done;
    logic nb_rd;
    logic nb_take;
    logic j_inc;
    logic rp_rd;
    logic push_rp;
    logic flush;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic proc_ok;
    logic eq_zero;
    logic couple;
    logic d_last;
    logic j_more;
    logic nb_zero;
    logic row_ok;
    logic jd_last;
    logic can_push;
    logic pend_valid;
    logic out_free;
    logic clr_done;
  } ctl_sts_t;

  typedef struct packed {
    logic             kind;
    logic [ROW_W-1:0] row;
    logic [RES_W-1:0] value_res;
    logic [RES_W-1:0] pair_index;
  } res_t;

endpackage

// ===== rtl/hcb_item_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_item_if
// Input item channel: command, cell, slot and value.
// ----------------------------------------------------------------------------
interface hcb_item_if import hcb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic [CELL_W-1:0]       cell_req;
  logic [SLOT_W-1:0]       slot;
  logic signed [VAL_W-1:0] value;
  modport source (output valid, cmd, cell_req, slot, value, input ready);
  modport sink   (input valid, cmd, cell_req, slot, value, output ready);
endinterface

// ===== rtl/hcb_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_res_if
// Result channel: coupling pairs and row pointer entries.
// ----------------------------------------------------------------------------
interface hcb_res_if import hcb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [ROW_W-1:0] row;
  logic [RES_W-1:0] value_res;
  logic [RES_W-1:0] pair_index;
  logic             last;
  modport source (output valid, kind, row, value_res, pair_index, last, input ready);
  modport sink   (input valid, kind, row, value_res, pair_index, last, output ready);
endinterface

// ===== rtl/hcb_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface hcb_cfg_if import hcb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [CFG_DW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/hcb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_ctrl
// Sequencer that walks rows, own cell, neighbours and row pointer updates.
// ----------------------------------------------------------------------------
module hcb_ctrl import hcb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.is_clear) begin
            cmd.clr_start = 1'b1;
            state_next    = ST_CLEAR;
          end else if (sts.proc_ok) begin
            cmd.start  = 1'b1;
            state_next = ST_CNT_RD;
          end
        end
      end
      ST_CNT_RD: begin
        cmd.cnt_rd = 1'b1;
        state_next = ST_ROW_RD;
      end
      ST_ROW_RD: begin
        cmd.row_rd = 1'b1;
        state_next = ST_ROW_CHK;
      end
      ST_ROW_CHK: begin
        if (!sts.eq_zero) begin
          cmd.row_take = 1'b1;
          state_next   = ST_EQ_RD;
        end else if (sts.jd_last) begin
          state_next = ST_FLUSH;
        end else begin
          cmd.jd_inc = 1'b1;
          state_next = ST_ROW_RD;
        end
      end
      ST_EQ_RD: begin
        cmd.eq_rd  = 1'b1;
        state_next = ST_EQ_CHK;
      end
      ST_EQ_CHK: begin
        if (!sts.couple || sts.can_push) begin
          cmd.push_pair = sts.couple;
          if (sts.d_last) begin
            cmd.eq_done = 1'b1;
            state_next  = ST_NB_SEL;
          end else begin
            cmd.d_inc  = 1'b1;
            state_next = ST_EQ_RD;
          end
        end
      end
      ST_NB_SEL: begin
        if (sts.j_more) begin
          cmd.nb_rd  = 1'b1;
          state_next = ST_NB_CHK;
        end else begin
          state_next = ST_RP_RD;
        end
      end
      ST_NB_CHK: begin
        if (sts.nb_zero) begin
          cmd.j_inc  = 1'b1;
          state_next = ST_NB_SEL;
        end else begin
          cmd.nb_take = 1'b1;
          state_next  = ST_EQ_RD;
        end
      end
      ST_RP_RD: begin
        if (sts.row_ok) begin
          cmd.rp_rd  = 1'b1;
          state_next = ST_RP_EMIT;
        end else if (sts.jd_last) begin
          state_next = ST_FLUSH;
        end else begin
          cmd.jd_inc = 1'b1;
          state_next = ST_ROW_RD;
        end
      end
      ST_RP_EMIT: begin
        if (sts.can_push) begin
          cmd.push_rp = 1'b1;
          if (sts.jd_last) begin
            state_next = ST_FLUSH;
          end else begin
            cmd.jd_inc = 1'b1;
            state_next = ST_ROW_RD;
          end
        end
      end
      ST_FLUSH: begin
        if (!sts.pend_valid) begin
          state_next = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule

// ===== rtl/hcb_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_dp
// Datapath: tables, configuration, counters, held-back result and output.
// ----------------------------------------------------------------------------
module hcb_dp import hcb_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  ctl_cmd_t                cmd,
  output ctl_sts_t                sts,
  input  logic [CMD_W-1:0]        in_cmd,
  input  logic [CELL_W-1:0]       in_cell,
  input  logic [SLOT_W-1:0]       in_slot,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    cfg_valid,
  input  logic [CFG_IW-1:0]       cfg_index,
  input  logic [CFG_DW-1:0]       cfg_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output res_t                    out_res,
  output logic                    out_last
);

  // Configuration registers.
  logic [NEQ_W-1:0]   num_eq;
  logic [DOFS_W-1:0]  dofs;
  logic [NCELL_W-1:0] num_cells;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_eq    <= NEQ_W'(4096);
      dofs      <= DOFS_W'(1);
      num_cells <= NCELL_W'(1024);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_NUM_EQ:    num_eq    <= cfg_data[NEQ_W-1:0];
        CFG_DOFS:      dofs      <= cfg_data[DOFS_W-1:0];
        CFG_NUM_CELLS: num_cells <= cfg_data[NCELL_W-1:0];
        default: ;
      endcase
    end
  end

  logic [ND_W-1:0] nd;
  assign nd = (int'(dofs) > MAX_DOF) ? ND_W'(MAX_DOF) : ND_W'(dofs);

  // Walk registers.
  logic [CIDX_W-1:0] it_cell, src;
  logic [DOF_W-1:0]  jd, d;
  logic [NCNT_W-1:0] j;
  logic [ROW_W-1:0]  rowq;
  logic [RES_W-1:0]  rcnt, pair_counter;
  logic [RP_AW-1:0]  clr_addr;

  // Memories.
  logic [EQ_VW-1:0]  eq_mem [MAX_CELLS*MAX_DOF];
  logic [NB_VW-1:0]  nb_mem [MAX_CELLS*MAX_NEIGH];
  logic [NCNT_W-1:0] cnt_mem [MAX_CELLS];
  logic [RES_W-1:0]  rp_mem [RP_DEPTH];
  logic [EQ_VW-1:0]  eq_q;
  logic [NB_VW-1:0]  nb_q;
  logic [NCNT_W-1:0] cnt_q;
  logic [RES_W-1:0]  rp_q;

  logic cell_in;
  assign cell_in = int'(in_cell) < MAX_CELLS;

  logic eq_we, nb_we, cnt_we;
  assign eq_we  = cmd.accept && in_cmd == CMD_LOAD_EQ && cell_in
                  && int'(in_slot) < MAX_DOF;
  assign nb_we  = cmd.accept && in_cmd == CMD_LOAD_NB && cell_in
                  && int'(in_slot) < MAX_NEIGH;
  assign cnt_we = cmd.accept && in_cmd == CMD_LOAD_CNT && cell_in;

  logic [EQ_AW-1:0] eq_waddr, eq_raddr;
  logic [NB_AW-1:0] nb_waddr, nb_raddr;
  logic [EQ_VW-1:0] eq_wdata;
  logic [NB_VW-1:0] nb_wdata;
  logic [NCNT_W-1:0] cnt_wdata;

  assign eq_waddr = EQ_AW'(in_cell[CIDX_W-1:0]) * EQ_AW'(MAX_DOF)
                    + EQ_AW'(in_slot[DOF_W-1:0]);
  assign nb_waddr = NB_AW'(in_cell[CIDX_W-1:0]) * NB_AW'(MAX_NEIGH)
                    + NB_AW'(in_slot[NB_SW-1:0]);
  assign eq_wdata = (in_value >= 1 && in_value <= MAX_EQ)
                    ? EQ_VW'(in_value) : '0;
  assign nb_wdata = (in_value >= 1 && in_value <= MAX_CELLS)
                    ? NB_VW'(in_value) : '0;
  assign cnt_wdata = (in_value < 0) ? '0
                   : (in_value > MAX_NEIGH) ? NCNT_W'(MAX_NEIGH) : NCNT_W'(in_value);

  assign eq_raddr = cmd.row_rd
                    ? EQ_AW'(it_cell) * EQ_AW'(MAX_DOF) + EQ_AW'(jd)
                    : EQ_AW'(src) * EQ_AW'(MAX_DOF) + EQ_AW'(d);
  assign nb_raddr = NB_AW'(it_cell) * NB_AW'(MAX_NEIGH) + NB_AW'(j[NB_SW-1:0]);

  always_ff @(posedge clk) begin
    if (eq_we) eq_mem[eq_waddr] <= eq_wdata;
    if (cmd.row_rd || cmd.eq_rd) eq_q <= eq_mem[eq_raddr];
  end

  always_ff @(posedge clk) begin
    if (nb_we) nb_mem[nb_waddr] <= nb_wdata;
    if (cmd.nb_rd) nb_q <= nb_mem[nb_raddr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[in_cell[CIDX_W-1:0]] <= cnt_wdata;
    if (cmd.cnt_rd) cnt_q <= cnt_mem[it_cell];
  end

  // Row pointer store: cleared by a sweep, updated by row pointer entries.
  logic [RES_W-1:0] rp_new;
  logic [RP_AW-1:0] rp_waddr;
  logic             rp_we;
  assign rp_new   = rp_q + rcnt;
  assign rp_we    = cmd.clr_step || cmd.push_rp;
  assign rp_waddr = cmd.clr_step ? clr_addr : RP_AW'(rowq) + RP_AW'(1);

  always_ff @(posedge clk) begin
    if (rp_we) rp_mem[rp_waddr] <= cmd.clr_step ? '0 : rp_new;
    if (cmd.rp_rd) rp_q <= rp_mem[RP_AW'(rowq)];
  end

  // Held-back result, so that the last one of an item can be flagged.
  res_t pend, res_new;
  logic pend_valid;
  logic push;
  assign push = cmd.push_pair || cmd.push_rp;

  always_comb begin
    res_new = '0;
    if (cmd.push_rp) begin
      res_new.kind       = 1'b1;
      res_new.row        = rowq + ROW_W'(1);
      res_new.value_res  = rp_new;
      res_new.pair_index = pair_counter;
    end else begin
      res_new.kind       = 1'b0;
      res_new.row        = rowq;
      res_new.value_res  = RES_W'(eq_q - EQ_VW'(1));
      res_new.pair_index = pair_counter + RES_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid   <= 1'b0;
      out_valid    <= 1'b0;
      pair_counter <= '0;
      clr_addr     <= '0;
    end else begin
      if (push) begin
        pend       <= res_new;
        pend_valid <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
      if ((push && pend_valid) || cmd.flush) begin
        out_res   <= pend;
        out_last  <= cmd.flush;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.clr_start) begin
        pair_counter <= '0;
        clr_addr     <= '0;
      end else begin
        if (cmd.push_pair) pair_counter <= pair_counter + RES_W'(1);
        if (cmd.clr_step)  clr_addr     <= clr_addr + RP_AW'(1);
      end
    end
  end

  // The own cell may also be listed as a neighbour, so phase is tracked.
  logic nb_phase;
  always_ff @(posedge clk) begin
    if (cmd.row_take) nb_phase <= 1'b0;
    else if (cmd.eq_done) nb_phase <= 1'b1;
  end

  // Walk counters.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      it_cell <= in_cell[CIDX_W-1:0];
      jd      <= '0;
    end
    if (cmd.jd_inc) jd <= jd + DOF_W'(1);
    if (cmd.row_take) begin
      rowq <= ROW_W'(eq_q - EQ_VW'(1));
      rcnt <= '0;
      src  <= it_cell;
      d    <= '0;
      j    <= '0;
    end
    if (cmd.push_pair) rcnt <= rcnt + RES_W'(1);
    if (cmd.d_inc) d <= d + DOF_W'(1);
    if (cmd.nb_take) begin
      src <= CIDX_W'(nb_q - NB_VW'(1));
      d   <= '0;
    end
    // After the own cell j stays at zero; after a neighbour it moves on.
    if (cmd.eq_done && nb_phase) j <= j + NCNT_W'(1);
    if (cmd.j_inc) j <= j + NCNT_W'(1);
  end

  logic out_free;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    sts.is_clear   = in_cmd == CMD_CLEAR;
    sts.proc_ok    = in_cmd == CMD_PROCESS && NCELL_W'(in_cell) < num_cells
                     && cell_in && nd != '0;
    sts.eq_zero    = eq_q == '0;
    sts.couple     = eq_q != '0 && NEQ_W'(eq_q - EQ_VW'(1)) >= num_eq;
    sts.d_last     = ND_W'(d) + ND_W'(1) == nd;
    sts.j_more     = j < cnt_q;
    sts.nb_zero    = nb_q == '0;
    sts.row_ok     = rowq < num_eq && int'(rowq) < MAX_EQ;
    sts.jd_last    = ND_W'(jd) + ND_W'(1) == nd;
    sts.can_push   = !pend_valid || out_free;
    sts.pend_valid = pend_valid;
    sts.out_free   = out_free;
    sts.clr_done   = int'(clr_addr) == MAX_EQ;
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push && pend_valid) |-> out_free)
    else $error("result pushed while output register is occupied");
  a_rp_row: assert property (@(posedge clk) disable iff (rst)
    cmd.push_rp |-> (rowq < num_eq))
    else $error("row pointer written past the owned equations");
  a_clr_range: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_step |-> int'(clr_addr) <= MAX_EQ)
    else $error("clear sweep beyond the row pointer store");
  a_flush_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> !pend_valid)
    else $error("held result not drained by flush");

endmodule

// ===== rtl/halo_coupling_coo_builder_top.sv =====
`timescale 1ns / 1ps
// Load and ignored items are taken in the idle state, which they do not leave.
// A process item walks each row of the cell that has an equation: the own cell's
// equations, then those of each listed neighbour, then a row pointer entry, with
// one-port table reads. Each result is held back until the next one is found;
// the last leaves on flush. Reset and each clear run a sweep over the whole row
// pointer store; no item is taken during the sweep, configuration writes always.
// ----------------------------------------------------------------------------
// halo_coupling_coo_builder_top
// Builds the coupling part of a sparse matrix as (row, column) pairs.
// ----------------------------------------------------------------------------
module halo_coupling_coo_builder_top import hcb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  hcb_item_if.sink    item,
  hcb_res_if.source   result,
  hcb_cfg_if.sink     cfg
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;
  res_t     res;

  // The sequencer decides each step; the datapath holds all tables and counters.
  hcb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Configuration writes are taken in every cycle.
  assign cfg.ready = 1'b1;

  hcb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_cmd    (item.cmd),
    .in_cell   (item.cell_req),
    .in_slot   (item.slot),
    .in_value  (item.value),
    .cfg_valid (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_res   (res),
    .out_last  (result.last)
  );

  // The output register carries one transfer while the walk goes on.
  assign result.kind       = res.kind;
  assign result.row        = res.row;
  assign result.value_res  = res.value_res;
  assign result.pair_index = res.pair_index;

endmodule
